### rtl/nsr_pkg.sv
// Shared types and constants for the Newton square root block.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package nsr_pkg;

  // Word widths
  localparam int unsigned DATA_W     = 32;   // UQ16.16 root, radicand, guess
  localparam int unsigned TOL_W      = 16;   // UQ0.16 tolerance
  localparam int unsigned FRAC_W     = 16;   // fraction bits of UQ16.16
  localparam int unsigned SQ_W       = 64;   // UQ32.32 square and difference
  localparam int unsigned ITER_W     = 7;    // update count field
  localparam int unsigned DIVISOR_W  = 33;   // 2*x
  localparam int unsigned REM_W      = 34;   // partial remainder
  localparam int unsigned DIV_STEPS  = 64;   // one quotient bit per step
  localparam int unsigned DCNT_W     = $clog2(DIV_STEPS);
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values
  localparam logic [TOL_W-1:0]  TOL_RESET   = 16'd7;
  localparam logic [DATA_W-1:0] GUESS_RESET = 32'h0001_0000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOLERANCE     = 1'b0,
    CFG_INITIAL_GUESS = 1'b1
  } cfg_index_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIFF,
    ST_TEST,
    ST_DIVIDE,
    ST_UPDATE,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // take radicand, start from the guess
    logic square;     // register x*x
    logic diff;       // register |x*x - n| and its sign
    logic div_start;  // set up the divider
    logic div_step;   // one restoring step
    logic update;     // apply the quotient to x
    logic finish;     // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tol_met;
    logic x_zero;
    logic cap_hit;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

### rtl/nsr_in_if.sv
// Input channel: valid/ready handshake carrying one radicand word.
// Depends on nsr_pkg for the field width.
`default_nettype none

interface nsr_in_if;
  logic                           valid;
  logic                           ready;
  logic [nsr_pkg::DATA_W-1:0]     radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

`default_nettype wire

### rtl/nsr_out_if.sv
// Output channel: valid/ready handshake carrying root, converged flag, update count.
// Depends on nsr_pkg for the field widths.
`default_nettype none

interface nsr_out_if;
  logic                           valid;
  logic                           ready;
  logic [nsr_pkg::DATA_W-1:0]     root;
  logic                           converged;
  logic [nsr_pkg::ITER_W-1:0]     iterations;

  modport source (output valid, output root, output converged, output iterations,
                  input ready);
  modport sink   (input valid, input root, input converged, input iterations,
                  output ready);
endinterface

`default_nettype wire

### rtl/nsr_ctrl.sv
// Sequencer for the Newton iteration: issues datapath commands, owns handshakes.
// Depends on nsr_pkg for state, command and status types.
`default_nettype none

module nsr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             operand_valid,
  output logic                  operand_ready,
  output logic                  result_valid,
  input  wire logic             result_ready,
  input  wire nsr_pkg::status_t status,
  output nsr_pkg::cmd_t         cmd
);

  nsr_pkg::state_t state, state_next;
  logic            result_valid_next;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= nsr_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next        = state;
    cmd               = '0;
    operand_ready     = 1'b0;
    result_valid_next = result_valid && !result_ready;
    unique case (state)
      nsr_pkg::ST_IDLE: begin
        // take no word while reset is held
        operand_ready = !rst;
        if (operand_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = nsr_pkg::ST_SQUARE;
        end
      end
      nsr_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = nsr_pkg::ST_DIFF;
      end
      nsr_pkg::ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = nsr_pkg::ST_TEST;
      end
      nsr_pkg::ST_TEST: begin
        // stop on tolerance, zero estimate or cap; otherwise divide
        if (status.tol_met || status.x_zero || status.cap_hit) begin
          state_next = nsr_pkg::ST_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = nsr_pkg::ST_DIVIDE;
        end
      end
      nsr_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = nsr_pkg::ST_UPDATE;
        end
      end
      nsr_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = nsr_pkg::ST_SQUARE;
      end
      nsr_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!result_valid || result_ready) begin
          cmd.finish        = 1'b1;
          result_valid_next = 1'b1;
          state_next        = nsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nsr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/nsr_datapath.sv
// Datapath: config registers, estimate, squarer, bit-serial divider, result register.
// Depends on nsr_pkg for widths, register indexes and command/status types.
`default_nettype none

module nsr_datapath #(
  parameter int unsigned MAX_ITERATIONS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [nsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nsr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [nsr_pkg::DATA_W-1:0]      radicand,
  input  wire nsr_pkg::cmd_t                   cmd,
  output nsr_pkg::status_t                     status,
  output logic [nsr_pkg::DATA_W-1:0]           root,
  output logic                                 converged,
  output logic [nsr_pkg::ITER_W-1:0]           iterations
);

  localparam int unsigned DW = nsr_pkg::DATA_W;
  localparam int unsigned SW = nsr_pkg::SQ_W;
  localparam int unsigned RW = nsr_pkg::REM_W;

  logic [nsr_pkg::TOL_W-1:0]     tolerance;
  logic [DW-1:0]                 initial_guess;
  logic [DW-1:0]                 x;
  logic [DW-1:0]                 n;
  logic [SW-1:0]                 sq;
  logic [SW-1:0]                 mag;
  logic                          above;
  logic [RW-1:0]                 rem;
  logic [SW-1:0]                 dvd;
  logic [nsr_pkg::DIVISOR_W-1:0] divisor;
  logic [nsr_pkg::DCNT_W-1:0]    dcnt;
  logic [nsr_pkg::ITER_W-1:0]    count;

  logic [SW-1:0]                 target;
  logic [SW-1:0]                 limit;
  logic [RW-1:0]                 rem_shift;
  logic [RW:0]                   rem_sub;
  logic                          qbit;
  logic [DW:0]                   sum;
  logic [DW-1:0]                 x_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance     <= nsr_pkg::TOL_RESET;
      initial_guess <= nsr_pkg::GUESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nsr_pkg::CFG_TOLERANCE:     tolerance     <= cfg_data[nsr_pkg::TOL_W-1:0];
        nsr_pkg::CFG_INITIAL_GUESS: initial_guess <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // Radicand and tolerance in UQ32.32
  assign target = {{(SW-DW-nsr_pkg::FRAC_W){1'b0}}, n, {nsr_pkg::FRAC_W{1'b0}}};
  assign limit  = {{(SW-nsr_pkg::TOL_W-nsr_pkg::FRAC_W){1'b0}}, tolerance,
                   {nsr_pkg::FRAC_W{1'b0}}};

  // Stop conditions
  assign status.tol_met  = (mag <= limit);
  assign status.x_zero   = (x == '0);
  assign status.cap_hit  = (count >= nsr_pkg::ITER_W'(MAX_ITERATIONS));
  assign status.div_done = (dcnt == {nsr_pkg::DCNT_W{1'b1}});

  // Restoring divide step: shift in the next dividend bit, subtract if it fits
  assign rem_shift = {rem[RW-2:0], dvd[SW-1]};
  assign rem_sub   = {1'b0, rem_shift} - {{(RW+1-nsr_pkg::DIVISOR_W){1'b0}}, divisor};
  assign qbit      = !rem_sub[RW];

  // Apply the quotient (held in dvd) to x, clamp below at 0 and above at all ones
  assign sum = {1'b0, x} + {1'b0, dvd[DW-1:0]};
  always_comb begin
    if (above) begin
      x_next = (dvd >= {{(SW-DW){1'b0}}, x}) ? '0 : x - dvd[DW-1:0];
    end else if ((dvd[SW-1:DW] != '0) || sum[DW]) begin
      x_next = '1;
    end else begin
      x_next = sum[DW-1:0];
    end
  end

  // Estimate, square, difference and update count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x     <= initial_guess;
      n     <= radicand;
      count <= '0;
    end else if (cmd.update) begin
      x     <= x_next;
      count <= count + 1'b1;
    end
    if (cmd.square) begin
      sq <= x * x;
    end
    if (cmd.diff) begin
      above <= (sq > target);
      mag   <= (sq > target) ? sq - target : target - sq;
    end
  end

  // Bit-serial divider: |x*x - n| / (2*x), quotient collects in dvd
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem     <= '0;
      dvd     <= mag;
      divisor <= {x, 1'b0};
      dcnt    <= '0;
    end else if (cmd.div_step) begin
      rem  <= qbit ? rem_sub[RW-1:0] : rem_shift;
      dvd  <= {dvd[SW-2:0], qbit};
      dcnt <= dcnt + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      root       <= x;
      converged  <= status.tol_met;
      iterations <= count;
    end
  end

endmodule

`default_nettype wire

### rtl/newton_square_root.sv
// Newton-Raphson square root of a UQ16.16 radicand, one item at a time.
// Depends on nsr_pkg, nsr_in_if, nsr_out_if, nsr_ctrl and nsr_datapath.
//
// Each radicand starts from the initial_guess register and is refined by
// x = x -/+ |x*x - n| / (2x) until |x*x - n| <= tolerance (both in UQ32.32),
// until MAX_ITERATIONS updates are done (converged 0) or until x is 0.
// One Newton update runs square, difference, test, a restoring divide of the
// 64-bit difference by 2x, and the update. A new radicand is accepted once
// the previous one has reached the result register, even while that result
// still waits to be taken. There is no clearing pass after reset.
`default_nettype none

module newton_square_root #(
  parameter int unsigned MAX_ITERATIONS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  nsr_in_if.sink                               operand,
  nsr_out_if.source                            result,
  input  wire logic                            cfg_we,
  input  wire logic [nsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nsr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  nsr_pkg::cmd_t    cmd;
  nsr_pkg::status_t status;

  // Sequencer
  nsr_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .operand_valid (operand.valid),
    .operand_ready (operand.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .status        (status),
    .cmd           (cmd)
  );

  // Arithmetic
  nsr_datapath #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .radicand   (operand.radicand),
    .cmd        (cmd),
    .status     (status),
    .root       (result.root),
    .converged  (result.converged),
    .iterations (result.iterations)
  );

endmodule

`default_nettype wire

### rtl/nsr_checker.sv
// Port-level checks for newton_square_root, attached by bind below.
// Depends on nsr_pkg for field widths.
`default_nettype none

module nsr_checker #(
  parameter int unsigned MAX_ITERATIONS = 32
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        operand_valid,
  input wire logic                        operand_ready,
  input wire logic                        result_valid,
  input wire logic                        result_ready,
  input wire logic [nsr_pkg::DATA_W-1:0]  root,
  input wire logic                        converged,
  input wire logic [nsr_pkg::ITER_W-1:0]  iterations
);

  // A stalled word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(root) && $stable(converged) && $stable(iterations))
    else $error("result word changed while stalled");

  // Busy right after taking a radicand
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    operand_valid && operand_ready |=> !operand_ready)
    else $error("operand accepted while an item is in progress");

  // Update count never exceeds the cap
  a_iter_cap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> iterations <= nsr_pkg::ITER_W'(MAX_ITERATIONS))
    else $error("iterations above cap");

  // Early stop without convergence only comes from a zero estimate
  a_zero_stop: assert property (@(posedge clk) disable iff (rst)
    result_valid && !converged && (iterations != nsr_pkg::ITER_W'(MAX_ITERATIONS))
      |-> root == '0)
    else $error("unconverged early stop with nonzero root");

endmodule

bind newton_square_root nsr_checker #(
  .MAX_ITERATIONS (MAX_ITERATIONS)
) u_nsr_checker (
  .clk           (clk),
  .rst           (rst),
  .operand_valid (operand.valid),
  .operand_ready (operand.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .root          (result.root),
  .converged     (result.converged),
  .iterations    (result.iterations)
);

`default_nettype wire

### tb/sv/newton_square_root_tb.sv
// Self-checking bench for newton_square_root: drives radicands and register writes,
// predicts each root, converged flag and update count, and checks every result word.
// Depends on nsr_pkg, nsr_in_if, nsr_out_if and the newton_square_root RTL.

module newton_square_root_tb;
  import nsr_pkg::*;

  localparam int MAX_UPDATES      = 32;
  localparam int PHASES           = 9;
  localparam int RANDOM_PER_PHASE = 90;
  localparam int LONG_HOLD        = 3000;
  localparam int HOLD_AFTER       = 40;
  localparam int QUIET_LIMIT      = 20000;
  localparam int TAIL_CYCLES      = 80;
  localparam int REPORT_LIMIT     = 10;

  typedef struct {
    logic [DATA_W-1:0] radicand;
    logic [DATA_W-1:0] root;
    logic              converged;
    logic [ITER_W-1:0] iterations;
  } root_word_t;

  // Predict each root from the radicand and the current register copies
  class root_tracker;
    logic [TOL_W-1:0]  tolerance;
    logic [DATA_W-1:0] initial_guess;
    root_word_t        roots_due[$];
    int                mismatch_count;

    function new();
      tolerance      = TOL_RESET;
      initial_guess  = GUESS_RESET;
      mismatch_count = 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_TOLERANCE) tolerance = value[TOL_W-1:0];
      else initial_guess = value[DATA_W-1:0];
    endfunction

    // Run the fixed-point Newton loop on an accepted radicand
    function void note_radicand(logic [DATA_W-1:0] n);
      logic [63:0] x, target, limit, sq, mag, step, sum;
      bit          above, done;
      int          count;
      root_word_t  want;
      x      = {32'd0, initial_guess};
      target = {16'd0, n, 16'd0};
      limit  = {32'd0, tolerance, 16'd0};
      count  = 0;
      done   = 0;
      want.radicand = n;
      while (!done) begin
        sq    = x * x;
        above = sq > target;
        mag   = above ? sq - target : target - sq;
        if (mag <= limit) begin
          want.root      = x[DATA_W-1:0];
          want.converged = 1'b1;
          done           = 1;
        end else if (x == 64'd0) begin
          want.root      = '0;
          want.converged = 1'b0;
          done           = 1;
        end else if (count >= MAX_UPDATES) begin
          want.root      = x[DATA_W-1:0];
          want.converged = 1'b0;
          done           = 1;
        end else begin
          step = mag / (x << 1);
          if (above) begin
            x = (step >= x) ? 64'd0 : x - step;
          end else begin
            // saturate an upward step at the top of the range
            sum = x + step;
            x   = (sum > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : sum;
          end
          count++;
        end
      end
      want.iterations = count[ITER_W-1:0];
      roots_due.push_back(want);
    endfunction

    // Compare a result word with the oldest prediction
    function void check_root(logic [DATA_W-1:0] root, logic converged,
                             logic [ITER_W-1:0] iterations);
      root_word_t want;
      if (roots_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result word: root %h converged %0b iterations %0d",
                   root, converged, iterations);
        return;
      end
      want = roots_due.pop_front();
      if (root !== want.root || converged !== want.converged ||
          iterations !== want.iterations) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("radicand %h: expected root %h conv %0b iter %0d, got %h %0b %0d",
                   want.radicand, want.root, want.converged, want.iterations,
                   root, converged, iterations);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    idle_pct;
  int                    quiet_cycles;

  nsr_in_if  operand_ch();
  nsr_out_if result_ch();

  root_tracker tracker;

  newton_square_root #(.MAX_ITERATIONS(MAX_UPDATES)) uut (
    .clk       (clk),
    .rst       (rst),
    .operand   (operand_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Note accepted radicands, check taken results, count quiet cycles
  always @(posedge clk) begin
    if (!rst) begin
      if (operand_ch.valid && operand_ch.ready)
        tracker.note_radicand(operand_ch.radicand);
      if (result_ch.valid && result_ch.ready)
        tracker.check_root(result_ch.root, result_ch.converged, result_ch.iterations);
      if ((operand_ch.valid && operand_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Drive ready: random idling, plus one long hold once results flow
  initial begin
    int  taken;
    bit  hold_done;
    taken     = 0;
    hold_done = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready) taken++;
      if (!hold_done && taken >= HOLD_AFTER) begin
        hold_done = 1;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      result_ch.ready <= !rst && ($urandom_range(99) >= idle_pct);
    end
  end

  // Write both registers on back-to-back cycles
  task automatic write_settings(logic [TOL_W-1:0] tol, logic [DATA_W-1:0] guess);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TOLERANCE;
    cfg_data  <= {16'd0, tol};
    tracker.set_register(CFG_TOLERANCE, {16'd0, tol});
    @(posedge clk);
    cfg_index <= CFG_INITIAL_GUESS;
    cfg_data  <= guess;
    tracker.set_register(CFG_INITIAL_GUESS, guess);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one radicand word, with an optional random gap ahead of it
  task automatic send_radicand(logic [DATA_W-1:0] n);
    while ($urandom_range(99) < idle_pct) begin
      operand_ch.valid <= 1'b0;
      @(posedge clk);
    end
    operand_ch.valid    <= 1'b1;
    operand_ch.radicand <= n;
    do @(posedge clk); while (!operand_ch.ready);
  endtask

  // Hold until every predicted root has been taken
  task automatic await_roots();
    @(posedge clk);
    while (tracker.roots_due.size() != 0) @(posedge clk);
  endtask

  // Mostly small radicands; squares and near squares; some over the full range
  function automatic logic [DATA_W-1:0] random_radicand(bit squares);
    int          pick;
    logic [31:0] k;
    pick = $urandom_range(99);
    if (squares || (pick >= 60 && pick < 75)) begin
      k = $urandom_range(0, squares ? 1023 : 4095);
      return k * k + (($urandom_range(3) == 0) ? $urandom_range(0, 6) : 0);
    end
    if (pick < 40) return $urandom_range(0, 32'h0032_0000);
    if (pick < 60) return $urandom_range(0, 32'h0000_FFFF);
    if (pick < 83) return $urandom_range(0, 32'h00FF_FFFF);
    return $urandom;
  endfunction

  initial begin
    logic [DATA_W-1:0] picks[$];
    logic [TOL_W-1:0]  tol_pick;
    logic [DATA_W-1:0] guess_pick;
    int                ph;
    int                k;
    tracker             = new();
    idle_pct            = 30;
    quiet_cycles        = 0;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_TOLERANCE;
    cfg_data           <= '0;
    operand_ch.valid    <= 1'b0;
    operand_ch.radicand <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (ph = 0; ph < PHASES; ph++) begin
      idle_pct = (ph == 4) ? 0 : 30;
      picks.delete();
      case (ph)
        // reset settings: extremes, guess already good, edges of the tolerance
        0: picks = {32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
                    32'h0001_0006, 32'h0001_0008, 32'h0004_0000, 32'h0002_0000,
                    32'h0000_8000, 32'h0000_FFFF, 32'h0031_0000, 32'h8000_0000,
                    32'h5555_5555, 32'hAAAA_AAAA};
        // widest tolerance, largest guess
        1: begin
          write_settings(16'hFFFF, 32'hFFFF_FFFF);
          picks = {32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFE_0001};
        end
        // tiny guess: first upward step saturates
        2: begin
          write_settings(16'd7, 32'd1);
          picks = {32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001};
        end
        // zero estimate: stop without dividing
        3: begin
          write_settings(16'd0, 32'd0);
          picks = {32'h0000_0000, 32'h0000_0005, 32'hFFFF_FFFF};
        end
        // exact match only, on squares and near squares
        4: write_settings(16'd0, GUESS_RESET);
        default: begin
          tol_pick   = TOL_W'(($urandom_range(1) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(0, 16'hFFFF));
          guess_pick = ($urandom_range(1) == 0) ? $urandom_range(1, 32'h0004_0000)
                                                : $urandom_range(1, 32'hFFFF_FFFF);
          write_settings(tol_pick, guess_pick);
        end
      endcase

      foreach (picks[i]) send_radicand(picks[i]);
      if (ph != 3) begin
        for (k = 0; k < RANDOM_PER_PHASE; k++) begin
          // pause the sender once until the pipe is empty
          if (ph == 5 && k == RANDOM_PER_PHASE / 2) begin
            operand_ch.valid <= 1'b0;
            await_roots();
          end
          send_radicand(random_radicand(ph == 4));
        end
      end
      operand_ch.valid <= 1'b0;
      await_roots();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.roots_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
